FILE: rtl/rcxf_pkg.sv
// Package: shared types, constants and register codes for the reflected CRC block.
`default_nettype none

package rcxf_pkg;

    localparam int CRC_W      = 32;
    localparam int HALF_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int HASH_W     = 16;
    localparam int FOLD_CFG_W = 5;
    localparam int FOLD_MAX   = 16;
    localparam int FOLD_SEL_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CRC_W-1:0]      CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [HALF_W-1:0]     HALF_MASK  = 16'hFFFF;
    localparam logic [CRC_W-1:0]      POLY_RESET = 32'h04C1_1DB7;
    localparam logic                  WIDE_RESET = 1'b1;
    localparam logic [FOLD_CFG_W-1:0] FOLD_RESET = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLYNOMIAL = 2'd0,
        REG_WIDE_MODE  = 2'd1,
        REG_FOLD_BITS  = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [CRC_W-1:0]      polynomial;
        logic                  wide_mode;
        logic [FOLD_CFG_W-1:0] fold_bits;
    } t_cfg;

endpackage

`default_nettype wire

FILE: rtl/rcxf_if.sv
// Interfaces: key byte input, result output and register write channels.
`default_nettype none

interface rcxf_in_if import rcxf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rcxf_out_if import rcxf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CRC_W-1:0]  crc_value;
    logic [HASH_W-1:0] bucket_index;

    modport source (output valid, output crc_value, output bucket_index, input ready);
    modport sink   (input valid, input crc_value, input bucket_index, output ready);
endinterface

interface rcxf_cfg_if import rcxf_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/rcxf_cfg_regs.sv
// Configuration registers: polynomial, width mode and fold width.
`default_nettype none

module rcxf_cfg_regs
    import rcxf_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    rcxf_cfg_if.sink  i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_POLYNOMIAL: n_cfg.polynomial = i_cfg.data;
                REG_WIDE_MODE:  n_cfg.wide_mode  = i_cfg.data[0];
                REG_FOLD_BITS:  n_cfg.fold_bits  = i_cfg.data[FOLD_CFG_W-1:0];
                default:        n_cfg            = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.polynomial <= POLY_RESET;
            r_cfg.wide_mode  <= WIDE_RESET;
            r_cfg.fold_bits  <= FOLD_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rcxf_crc_byte.sv
// Byte-wide reflected CRC update, eight bit steps with the reversed polynomial.
`default_nettype none

module rcxf_crc_byte
    import rcxf_pkg::*;
(
    input  wire  [CRC_W-1:0]  i_crc,
    input  wire  [BYTE_W-1:0] i_byte,
    input  wire  t_cfg        i_cfg,
    output logic [CRC_W-1:0]  o_crc
);

    logic [CRC_W-1:0] w_rpoly;
    logic [CRC_W-1:0] w_crc;

    always_comb begin
        w_rpoly = '0;
        for (int i = 0; i < CRC_W; i++) begin
            w_rpoly[i] = i_cfg.polynomial[CRC_W-1-i];
        end
        // narrow mode reverses only the low half
        if (!i_cfg.wide_mode) begin
            w_rpoly = '0;
            for (int i = 0; i < HALF_W; i++) begin
                w_rpoly[i] = i_cfg.polynomial[HALF_W-1-i];
            end
        end
    end

    always_comb begin
        w_crc = i_cfg.wide_mode ? i_crc : {{(CRC_W-HALF_W){1'b0}}, i_crc[HALF_W-1:0]};
        w_crc = w_crc ^ {{(CRC_W-BYTE_W){1'b0}}, i_byte};
        for (int k = 0; k < BYTE_W; k++) begin
            w_crc = w_crc[0] ? ((w_crc >> 1) ^ w_rpoly) : (w_crc >> 1);
        end
        o_crc = w_crc;
    end

endmodule

`default_nettype wire

FILE: rtl/rcxf_fold.sv
// XOR fold of the finished CRC into chunks of the programmed width.
`default_nettype none

module rcxf_fold
    import rcxf_pkg::*;
(
    input  wire  [CRC_W-1:0]      i_crc,
    input  wire  [FOLD_CFG_W-1:0] i_fold_bits,
    output logic [HASH_W-1:0]     o_hash
);

    logic [HASH_W-1:0]     w_fold [FOLD_MAX];
    logic [FOLD_SEL_W-1:0] w_sel;

    // one fold per chunk width; upper CRC bits are zero in narrow mode
    always_comb begin
        for (int f = 1; f <= FOLD_MAX; f++) begin
            w_fold[f-1] = '0;
            for (int off = 0; off < CRC_W; off += f) begin
                w_fold[f-1] = w_fold[f-1] ^ (HASH_W'(i_crc >> off) & HASH_W'((1 << f) - 1));
            end
        end
    end

    // zero acts as one, anything above the maximum saturates
    always_comb begin
        if (i_fold_bits == '0) begin
            w_sel = '0;
        end else if (i_fold_bits > FOLD_CFG_W'(FOLD_MAX)) begin
            w_sel = FOLD_SEL_W'(FOLD_MAX - 1);
        end else begin
            w_sel = FOLD_SEL_W'(i_fold_bits - FOLD_CFG_W'(1));
        end
        o_hash = w_fold[w_sel];
    end

endmodule

`default_nettype wire

FILE: rtl/reflected_crc_with_xor_fold_core.sv
// Top level: input register, byte CRC update and fold, output register.
// A key's last word passes from the input register through the byte update and fold
// into the output register. One word per cycle unless a last word meets an untaken
// result; the CRC register loop closes through the byte update. The output register
// lets a new word enter while a result waits to be taken. Reset (synchronous, active
// low) empties both registers, sets the CRC to all ones and restores register defaults.
`default_nettype none

module reflected_crc_with_xor_fold_core
    import rcxf_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    rcxf_in_if.sink    i_in,
    rcxf_cfg_if.sink   i_cfg,
    rcxf_out_if.source o_out
);

    t_cfg w_cfg;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic [CRC_W-1:0]  r_crc;
    logic              r_out_valid;
    logic [CRC_W-1:0]  r_out_crc;
    logic [HASH_W-1:0] r_out_hash;

    logic [CRC_W-1:0]  w_next_crc;
    logic [CRC_W-1:0]  w_result;
    logic [HASH_W-1:0] w_hash;
    logic              w_advance;
    logic              w_take;

    rcxf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    rcxf_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (r_in_byte),
        .i_cfg  (w_cfg),
        .o_crc  (w_next_crc)
    );

    assign w_result = w_cfg.wide_mode ? ~w_next_crc
                                      : {{(CRC_W-HALF_W){1'b0}}, w_next_crc[HALF_W-1:0] & HALF_MASK};

    rcxf_fold u_fold (
        .i_crc       (w_result),
        .i_fold_bits (w_cfg.fold_bits),
        .o_hash      (w_hash)
    );

    // a non-final word never needs the output register
    assign w_advance   = r_in_valid && (!r_in_last || !r_out_valid || o_out.ready);
    assign w_take      = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_in_valid || w_advance;

    assign o_out.valid        = r_out_valid;
    assign o_out.crc_value    = r_out_crc;
    assign o_out.bucket_index = r_out_hash;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_crc       <= CRC_INIT;
        end else begin
            if (w_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_crc <= r_in_last ? CRC_INIT : w_next_crc;
            end
            if (w_advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_byte <= i_in.data_byte;
            r_in_last <= i_in.last_byte;
        end
        if (w_advance && r_in_last) begin
            r_out_crc  <= w_result;
            r_out_hash <= w_hash;
        end
    end

`ifndef SYNTH
    a_crc_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_last) |=> (r_crc == CRC_INIT))
        else $error("CRC register not restarted after last word");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> i_in.ready)
        else $error("input not ready with empty input register");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_advance && r_in_last))
        else $error("result appeared without a last word");
`endif

endmodule

`default_nettype wire
